@@ rtl/core/heading_pid_turn_controller_macros.svh @@
// Assertion macros for the heading turn controller.
// Define NO_ASSERTIONS to compile every check away.
`ifndef HEADING_PID_TURN_CONTROLLER_MACROS_SVH
`define HEADING_PID_TURN_CONTROLLER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that the consequent holds in the same cycle as the antecedent
`define HPTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("heading controller: same-cycle check failed");
// Check that the consequent holds in the cycle after the antecedent
`define HPTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("heading controller: next-cycle check failed");
`else
`define HPTC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HPTC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/hptc_pkg.sv @@
`default_nettype none

package hptc_pkg;

	// Field and state widths
	localparam int HEAD_W  = 12;
	localparam int ERR_W   = 13;
	localparam int DERIV_W = 14;
	localparam int INTEG_W = 32;
	localparam int DRIVE_W = 8;
	localparam int BAND_W  = 16;
	localparam int PP_W    = 30;
	localparam int PI_W    = 49;
	localparam int PD_W    = 31;
	localparam int SUM_W   = 50;

	// Control tick length in milliseconds
	localparam logic [BAND_W:0] TICK_MS = 17'd10;

	localparam logic signed [INTEG_W-1:0] INTEG_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [INTEG_W-1:0] INTEG_MIN = 32'sh8000_0000;
	localparam logic [BAND_W-1:0]         BAND_MAX  = 16'hFFFF;

	// Register reset values
	localparam logic [15:0] RST_PROP_GAIN   = 16'd256;
	localparam logic [15:0] RST_INTEG_GAIN  = 16'd0;
	localparam logic [15:0] RST_DERIV_GAIN  = 16'd0;
	localparam logic [6:0]  RST_MAX_OUTPUT  = 7'd127;
	localparam logic [6:0]  RST_MIN_SPEED   = 7'd0;
	localparam logic [11:0] RST_SETTLE_THR  = 12'd10;
	localparam logic [15:0] RST_SETTLE_TIME = 16'd100;
	localparam logic [7:0]  RST_SLEW_LIMIT  = 8'd255;

	typedef enum logic [2:0] {
		CFG_PROP_GAIN   = 3'd0,
		CFG_INTEG_GAIN  = 3'd1,
		CFG_DERIV_GAIN  = 3'd2,
		CFG_MAX_OUTPUT  = 3'd3,
		CFG_MIN_SPEED   = 3'd4,
		CFG_SETTLE_THR  = 3'd5,
		CFG_SETTLE_TIME = 3'd6,
		CFG_SLEW_LIMIT  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] prop_gain;
		logic [15:0] integ_gain;
		logic [15:0] deriv_gain;
		logic [6:0]  max_output;
		logic [6:0]  min_speed;
		logic [11:0] settle_threshold;
		logic [15:0] settle_time;
		logic [7:0]  slew_limit;
	} cfg_t;

	// Stage load strobes from the pipeline control
	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
		logic ld_out;
	} pipe_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/hptc_err_stage.sv @@
`default_nettype none

module hptc_err_stage (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        load,
	input  wire hptc_pkg::cfg_t                              cfg,
	input  wire logic                                        start_s1,
	input  wire logic [hptc_pkg::HEAD_W-1:0]                 target_s1,
	input  wire logic [hptc_pkg::HEAD_W-1:0]                 measured_s1,
	output logic signed [hptc_pkg::ERR_W-1:0]                err_s2,
	output logic signed [hptc_pkg::INTEG_W-1:0]              integ_s2,
	output logic signed [hptc_pkg::DERIV_W-1:0]              deriv_s2,
	output logic [hptc_pkg::HEAD_W-1:0]                      aerr_s2,
	output logic                                             done_s2,
	output logic                                             start_s2
);

	logic signed [hptc_pkg::INTEG_W-1:0] integral_q;
	logic signed [hptc_pkg::ERR_W-1:0]   prev_err_q;
	logic [hptc_pkg::BAND_W-1:0]         in_band_q;

	logic signed [hptc_pkg::INTEG_W-1:0] integ_base;
	logic signed [hptc_pkg::ERR_W-1:0]   prev_base;
	logic [hptc_pkg::BAND_W-1:0]         band_base;
	logic signed [hptc_pkg::ERR_W-1:0]   err;
	logic [hptc_pkg::ERR_W-1:0]          err_neg;
	logic [hptc_pkg::HEAD_W-1:0]         aerr;
	logic signed [hptc_pkg::INTEG_W:0]   integ_wide;
	logic signed [hptc_pkg::INTEG_W-1:0] integ_next;
	logic [10:0]                         reset_lim;
	logic signed [hptc_pkg::DERIV_W-1:0] deriv;
	logic [hptc_pkg::BAND_W:0]           band_sum;
	logic [hptc_pkg::BAND_W-1:0]         band_next;

	// Clear the carried state on a start transaction
	assign integ_base = start_s1 ? '0 : integral_q;
	assign prev_base  = start_s1 ? '0 : prev_err_q;
	assign band_base  = start_s1 ? '0 : in_band_q;

	// Heading error and its magnitude, no angular wrap
	assign err     = $signed({1'b0, target_s1}) - $signed({1'b0, measured_s1});
	assign err_neg = -err;
	assign aerr    = err[hptc_pkg::ERR_W-1] ? err_neg[hptc_pkg::HEAD_W-1:0]
	                                        : err[hptc_pkg::HEAD_W-1:0];

	// Saturating integral, dropped when the error is beyond ten times the clamp
	assign integ_wide = {integ_base[hptc_pkg::INTEG_W-1], integ_base}
	                  + {{(hptc_pkg::INTEG_W+1-hptc_pkg::ERR_W){err[hptc_pkg::ERR_W-1]}}, err};
	assign reset_lim  = {1'b0, cfg.max_output, 3'b000} + {3'b000, cfg.max_output, 1'b0};

	always_comb begin
		if (integ_wide[hptc_pkg::INTEG_W] != integ_wide[hptc_pkg::INTEG_W-1]) begin
			integ_next = integ_wide[hptc_pkg::INTEG_W] ? hptc_pkg::INTEG_MIN
			                                           : hptc_pkg::INTEG_MAX;
		end else begin
			integ_next = integ_wide[hptc_pkg::INTEG_W-1:0];
		end
		if (aerr > {1'b0, reset_lim}) begin
			integ_next = '0;
		end
	end

	// Derivative against the previous error
	assign deriv = {err[hptc_pkg::ERR_W-1], err} - {prev_base[hptc_pkg::ERR_W-1], prev_base};

	// In-band timer, saturating
	assign band_sum = {1'b0, band_base} + hptc_pkg::TICK_MS;

	always_comb begin
		if (aerr < cfg.settle_threshold) begin
			band_next = band_sum[hptc_pkg::BAND_W] ? hptc_pkg::BAND_MAX
			                                       : band_sum[hptc_pkg::BAND_W-1:0];
		end else begin
			band_next = '0;
		end
	end

	// Advance the carried state with each transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			prev_err_q <= '0;
			in_band_q  <= '0;
		end else if (load) begin
			integral_q <= integ_next;
			prev_err_q <= err;
			in_band_q  <= band_next;
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (load) begin
			err_s2   <= err;
			integ_s2 <= integ_next;
			deriv_s2 <= deriv;
			aerr_s2  <= aerr;
			done_s2  <= (band_next >= cfg.settle_time);
			start_s2 <= start_s1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hptc_mul_stage.sv @@
`default_nettype none

module hptc_mul_stage (
	input  wire logic                                 clk,
	input  wire logic                                 load,
	input  wire hptc_pkg::cfg_t                       cfg,
	input  wire logic signed [hptc_pkg::ERR_W-1:0]    err_s2,
	input  wire logic signed [hptc_pkg::INTEG_W-1:0]  integ_s2,
	input  wire logic signed [hptc_pkg::DERIV_W-1:0]  deriv_s2,
	input  wire logic [hptc_pkg::HEAD_W-1:0]          aerr_s2,
	input  wire logic                                 done_s2,
	input  wire logic                                 start_s2,
	output logic signed [hptc_pkg::PP_W-1:0]          pp_s3,
	output logic signed [hptc_pkg::PI_W-1:0]          pi_s3,
	output logic signed [hptc_pkg::PD_W-1:0]          pd_s3,
	output logic [hptc_pkg::HEAD_W-1:0]               aerr_s3,
	output logic                                      done_s3,
	output logic                                      start_s3
);

	logic signed [16:0]                kp;
	logic signed [16:0]                ki;
	logic signed [16:0]                kd;
	logic signed [hptc_pkg::PP_W-1:0]  pp;
	logic signed [hptc_pkg::PI_W-1:0]  pi;
	logic signed [hptc_pkg::PD_W-1:0]  pd;

	// Gains are unsigned Q8.8; widen by a zero so the products stay signed
	assign kp = $signed({1'b0, cfg.prop_gain});
	assign ki = $signed({1'b0, cfg.integ_gain});
	assign kd = $signed({1'b0, cfg.deriv_gain});

	assign pp = kp * err_s2;
	assign pi = ki * integ_s2;
	assign pd = kd * deriv_s2;

	// Register the three products
	always_ff @(posedge clk) begin
		if (load) begin
			pp_s3    <= pp;
			pi_s3    <= pi;
			pd_s3    <= pd;
			aerr_s3  <= aerr_s2;
			done_s3  <= done_s2;
			start_s3 <= start_s2;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hptc_shape_stage.sv @@
`default_nettype none

module hptc_shape_stage (
	input  wire logic                                 clk,
	input  wire logic                                 load,
	input  wire hptc_pkg::cfg_t                       cfg,
	input  wire logic signed [hptc_pkg::PP_W-1:0]     pp_s3,
	input  wire logic signed [hptc_pkg::PI_W-1:0]     pi_s3,
	input  wire logic signed [hptc_pkg::PD_W-1:0]     pd_s3,
	input  wire logic [hptc_pkg::HEAD_W-1:0]          aerr_s3,
	input  wire logic                                 done_s3,
	input  wire logic                                 start_s3,
	output logic signed [hptc_pkg::DRIVE_W-1:0]       y_s4,
	output logic                                      done_s4,
	output logic                                      start_s4
);

	logic signed [hptc_pkg::SUM_W-1:0] sum;
	logic                              neg;
	logic [hptc_pkg::SUM_W-1:0]        sum_mag;
	logic [hptc_pkg::SUM_W-9:0]        mag;
	logic [6:0]                        mag_clamp;
	logic [6:0]                        out_mag;
	logic                              out_neg;
	logic [hptc_pkg::DRIVE_W-1:0]      y;

	// PID sum in Q8.8, then truncate toward zero
	assign sum     = hptc_pkg::SUM_W'(pp_s3) + hptc_pkg::SUM_W'(pi_s3)
	               + hptc_pkg::SUM_W'(pd_s3);
	assign neg     = sum[hptc_pkg::SUM_W-1];
	assign sum_mag = neg ? -sum : sum;
	assign mag     = sum_mag[hptc_pkg::SUM_W-1:8];

	// Clamp to the output limit
	assign mag_clamp = ((|mag[hptc_pkg::SUM_W-9:7]) || (mag[6:0] > cfg.max_output))
	                 ? cfg.max_output : mag[6:0];

	// Raise to the minimum speed while off target; zero goes negative
	always_comb begin
		out_mag = mag_clamp;
		out_neg = neg;
		if ((mag_clamp < cfg.min_speed) && (aerr_s3 > cfg.settle_threshold)) begin
			out_mag = cfg.min_speed;
			out_neg = neg || (mag_clamp == '0);
		end
	end

	assign y = out_neg ? -{1'b0, out_mag} : {1'b0, out_mag};

	always_ff @(posedge clk) begin
		if (load) begin
			y_s4     <= $signed(y);
			done_s4  <= done_s3;
			start_s4 <= start_s3;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/hptc_slew_stage.sv @@
`default_nettype none

module hptc_slew_stage (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 load,
	input  wire hptc_pkg::cfg_t                       cfg,
	input  wire logic signed [hptc_pkg::DRIVE_W-1:0]  y_s4,
	input  wire logic                                 done_s4,
	input  wire logic                                 start_s4,
	output logic signed [hptc_pkg::DRIVE_W-1:0]       left_q,
	output logic signed [hptc_pkg::DRIVE_W-1:0]       right_q,
	output logic                                      done_q
);

	logic signed [hptc_pkg::DRIVE_W-1:0] prev_out_q;
	logic signed [hptc_pkg::DRIVE_W-1:0] prev_base;
	logic signed [hptc_pkg::DRIVE_W:0]   delta;
	logic [hptc_pkg::DRIVE_W:0]          delta_mag;
	logic signed [hptc_pkg::DRIVE_W:0]   step_up;
	logic signed [hptc_pkg::DRIVE_W:0]   step_dn;
	logic signed [hptc_pkg::DRIVE_W-1:0] y_out;

	assign prev_base = start_s4 ? '0 : prev_out_q;

	// Limit the change against the previous output
	assign delta     = {y_s4[hptc_pkg::DRIVE_W-1], y_s4}
	                 - {prev_base[hptc_pkg::DRIVE_W-1], prev_base};
	assign delta_mag = delta[hptc_pkg::DRIVE_W] ? -delta : delta;
	assign step_up   = {prev_base[hptc_pkg::DRIVE_W-1], prev_base} + {1'b0, cfg.slew_limit};
	assign step_dn   = {prev_base[hptc_pkg::DRIVE_W-1], prev_base} - {1'b0, cfg.slew_limit};

	always_comb begin
		if (delta_mag > {1'b0, cfg.slew_limit}) begin
			y_out = delta[hptc_pkg::DRIVE_W] ? step_dn[hptc_pkg::DRIVE_W-1:0]
			                                 : step_up[hptc_pkg::DRIVE_W-1:0];
		end else begin
			y_out = y_s4;
		end
	end

	// Hold the last output for the next transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_out_q <= '0;
		end else if (load) begin
			prev_out_q <= y_out;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (load) begin
			right_q <= y_out;
			left_q  <= -y_out;
			done_q  <= done_s4;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/heading_pid_turn_controller.sv @@
// Heading PID turn controller.
// Input channel (in_valid/in_ready): one transaction per control tick carrying
// start_move, target_heading and measured_heading in tenths of a degree.
// Output channel (out_valid/out_ready): left_drive, right_drive and move_done
// for that tick, in order, exactly one result per input transaction.
// The user must write gains and limits (cfg_we/cfg_index/cfg_data) while idle;
// not enforced by the block. A write lands at the clock edge with cfg_we high.
// Pipeline: an accepted input runs through four stages: error and integral
// update, the three gain multipliers, the sum with clamp and minimum speed,
// then the slew limit into the result register.
// Throughput: one transaction per cycle while out_ready stays high.
// Stall: when out_ready is low the result register holds; the stages behind
// it keep filling until each holds an item, and in_ready falls only then.
// Reset: clears all controller state and restores the default registers;
// start_move clears integral, last error, last output and in-band time.
`default_nettype none
`include "heading_pid_turn_controller_macros.svh"

module heading_pid_turn_controller (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Configuration
	input  wire logic                                  cfg_we,
	input  wire logic [2:0]                            cfg_index,
	input  wire logic [15:0]                           cfg_data,
	// Input channel
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic                                  start_move,
	input  wire logic [hptc_pkg::HEAD_W-1:0]           target_heading,
	input  wire logic [hptc_pkg::HEAD_W-1:0]           measured_heading,
	// Output channel
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [hptc_pkg::DRIVE_W-1:0]        left_drive,
	output logic signed [hptc_pkg::DRIVE_W-1:0]        right_drive,
	output logic                                       move_done
);

	hptc_pkg::cfg_t      cfg_q;
	hptc_pkg::pipe_ctl_t ctl;

	logic valid_s1, valid_s2, valid_s3, valid_s4, out_valid_q;
	logic en_s1, en_s2, en_s3, en_s4, en_out;

	logic                                 start_s1;
	logic [hptc_pkg::HEAD_W-1:0]          target_s1;
	logic [hptc_pkg::HEAD_W-1:0]          measured_s1;

	logic signed [hptc_pkg::ERR_W-1:0]    err_s2;
	logic signed [hptc_pkg::INTEG_W-1:0]  integ_s2;
	logic signed [hptc_pkg::DERIV_W-1:0]  deriv_s2;
	logic [hptc_pkg::HEAD_W-1:0]          aerr_s2;
	logic                                 done_s2, start_s2;

	logic signed [hptc_pkg::PP_W-1:0]     pp_s3;
	logic signed [hptc_pkg::PI_W-1:0]     pi_s3;
	logic signed [hptc_pkg::PD_W-1:0]     pd_s3;
	logic [hptc_pkg::HEAD_W-1:0]          aerr_s3;
	logic                                 done_s3, start_s3;

	logic signed [hptc_pkg::DRIVE_W-1:0]  y_s4;
	logic                                 done_s4, start_s4;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain        <= hptc_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain       <= hptc_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain       <= hptc_pkg::RST_DERIV_GAIN;
			cfg_q.max_output       <= hptc_pkg::RST_MAX_OUTPUT;
			cfg_q.min_speed        <= hptc_pkg::RST_MIN_SPEED;
			cfg_q.settle_threshold <= hptc_pkg::RST_SETTLE_THR;
			cfg_q.settle_time      <= hptc_pkg::RST_SETTLE_TIME;
			cfg_q.slew_limit       <= hptc_pkg::RST_SLEW_LIMIT;
		end else if (cfg_we) begin
			case (hptc_pkg::cfg_idx_t'(cfg_index))
				hptc_pkg::CFG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_data;
				hptc_pkg::CFG_INTEG_GAIN:  cfg_q.integ_gain       <= cfg_data;
				hptc_pkg::CFG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_data;
				hptc_pkg::CFG_MAX_OUTPUT:  cfg_q.max_output       <= cfg_data[6:0];
				hptc_pkg::CFG_MIN_SPEED:   cfg_q.min_speed        <= cfg_data[6:0];
				hptc_pkg::CFG_SETTLE_THR:  cfg_q.settle_threshold <= cfg_data[11:0];
				hptc_pkg::CFG_SETTLE_TIME: cfg_q.settle_time      <= cfg_data;
				hptc_pkg::CFG_SLEW_LIMIT:  cfg_q.slew_limit       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Each stage advances when the one ahead is empty or moving on
	assign en_out   = !out_valid_q || out_ready;
	assign en_s4    = !valid_s4 || en_out;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	assign ctl.ld_s2  = valid_s1 && en_s2;
	assign ctl.ld_s3  = valid_s2 && en_s3;
	assign ctl.ld_s4  = valid_s3 && en_s4;
	assign ctl.ld_out = valid_s4 && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_out) out_valid_q <= valid_s4;
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (in_valid && en_s1) begin
			start_s1    <= start_move;
			target_s1   <= target_heading;
			measured_s1 <= measured_heading;
		end
	end

	hptc_err_stage u_err (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (ctl.ld_s2),
		.cfg         (cfg_q),
		.start_s1    (start_s1),
		.target_s1   (target_s1),
		.measured_s1 (measured_s1),
		.err_s2      (err_s2),
		.integ_s2    (integ_s2),
		.deriv_s2    (deriv_s2),
		.aerr_s2     (aerr_s2),
		.done_s2     (done_s2),
		.start_s2    (start_s2)
	);

	hptc_mul_stage u_mul (
		.clk      (clk),
		.load     (ctl.ld_s3),
		.cfg      (cfg_q),
		.err_s2   (err_s2),
		.integ_s2 (integ_s2),
		.deriv_s2 (deriv_s2),
		.aerr_s2  (aerr_s2),
		.done_s2  (done_s2),
		.start_s2 (start_s2),
		.pp_s3    (pp_s3),
		.pi_s3    (pi_s3),
		.pd_s3    (pd_s3),
		.aerr_s3  (aerr_s3),
		.done_s3  (done_s3),
		.start_s3 (start_s3)
	);

	hptc_shape_stage u_shape (
		.clk      (clk),
		.load     (ctl.ld_s4),
		.cfg      (cfg_q),
		.pp_s3    (pp_s3),
		.pi_s3    (pi_s3),
		.pd_s3    (pd_s3),
		.aerr_s3  (aerr_s3),
		.done_s3  (done_s3),
		.start_s3 (start_s3),
		.y_s4     (y_s4),
		.done_s4  (done_s4),
		.start_s4 (start_s4)
	);

	hptc_slew_stage u_slew (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (ctl.ld_out),
		.cfg      (cfg_q),
		.y_s4     (y_s4),
		.done_s4  (done_s4),
		.start_s4 (start_s4),
		.left_q   (left_drive),
		.right_q  (right_drive),
		.done_q   (move_done)
	);

	assign out_valid = out_valid_q;

	// Left side always mirrors the right side
	`HPTC_ASSERT_IMP(a_drive_mirror, clk, arst_n, out_valid_q, left_drive == -right_drive)
	// With no settle time every result reports the move finished
	`HPTC_ASSERT_IMP(a_done_zero_settle, clk, arst_n, out_valid_q && (cfg_q.settle_time == '0), move_done)
	// A result leaving the last stage appears on the output channel
	`HPTC_ASSERT_NXT(a_result_lands, clk, arst_n, ctl.ld_out, out_valid_q)

endmodule

`default_nettype wire

@@ bench/tb_heading_pid_turn_controller.sv @@
`timescale 1ns / 100ps

module tb_heading_pid_turn_controller;
	import hptc_pkg::*;

	typedef struct {
		logic              start_move;
		logic [HEAD_W-1:0] target_heading;
		logic [HEAD_W-1:0] measured_heading;
	} tick_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
		logic                      move_done;
	} drive_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_move = 1'b0;
	logic [HEAD_W-1:0] target_heading = '0;
	logic [HEAD_W-1:0] measured_heading = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;
	logic move_done;

	heading_pid_turn_controller dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.start_move       (start_move),
		.target_heading   (target_heading),
		.measured_heading (measured_heading),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.left_drive       (left_drive),
		.right_drive      (right_drive),
		.move_done        (move_done)
	);

	// Shadow of the register file and of the controller state
	cfg_t gains;
	logic signed [INTEG_W-1:0] integ_acc = '0;
	logic signed [ERR_W-1:0]   last_err  = '0;
	logic signed [DRIVE_W-1:0] last_out  = '0;
	int                        band_ms   = 0;

	tick_t  tick_pending[$];
	drive_t drive_expected[$];
	tick_t  cur_tick;
	int     gap_left = 0;
	int     stall_left = 0;
	int     in_gap_odds = 3;
	int     out_stall_odds = 3;
	int     fail_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	// Work out the drive command for one control tick and advance the shadow state
	function automatic drive_t compute_drive(tick_t t);
		longint tgt, meas, err, aerr, integ, deriv, sum, mag, y, delta, neg;
		longint kp, ki, kd, maxo, mins, thr, slew, prev_e, prev_y;
		drive_t r;
		if (t.start_move) begin
			integ_acc = '0;
			last_err  = '0;
			last_out  = '0;
			band_ms   = 0;
		end
		tgt    = t.target_heading;
		meas   = t.measured_heading;
		kp     = gains.prop_gain;
		ki     = gains.integ_gain;
		kd     = gains.deriv_gain;
		maxo   = gains.max_output;
		mins   = gains.min_speed;
		thr    = gains.settle_threshold;
		slew   = gains.slew_limit;
		prev_e = last_err;
		prev_y = last_out;

		err  = tgt - meas;
		aerr = (err < 0) ? -err : err;

		// Saturating integral, dropped when far off target
		integ = integ_acc;
		integ = integ + err;
		if (integ > INTEG_MAX)
			integ = INTEG_MAX;
		if (integ < INTEG_MIN)
			integ = INTEG_MIN;
		if (aerr > maxo * 10)
			integ = 0;
		integ_acc = integ[INTEG_W-1:0];

		deriv    = err - prev_e;
		last_err = err[ERR_W-1:0];

		// Q8.8 sum, truncate toward zero, then clamp
		sum = kp * err + ki * integ + kd * deriv;
		mag = ((sum < 0) ? -sum : sum) / 256;
		y   = (sum < 0) ? -mag : mag;
		if (y > maxo)
			y = maxo;
		if (y < -maxo)
			y = -maxo;

		// Raise to minimum speed while off target; zero goes negative
		if (((y < 0) ? -y : y) < mins && aerr > thr)
			y = (y > 0) ? mins : -mins;

		// Slew limit against the last command
		delta = y - prev_y;
		if (((delta < 0) ? -delta : delta) > slew)
			y = prev_y + ((delta > 0) ? slew : -slew);
		last_out = y[DRIVE_W-1:0];

		// Time in band
		if (aerr < thr) begin
			band_ms = band_ms + TICK_MS;
			if (band_ms > BAND_MAX)
				band_ms = BAND_MAX;
		end else begin
			band_ms = 0;
		end

		neg           = -y;
		r.left_drive  = neg[DRIVE_W-1:0];
		r.right_drive = y[DRIVE_W-1:0];
		r.move_done   = (band_ms >= gains.settle_time);
		return r;
	endfunction

	// Input driver: hold each transaction until accepted, predict on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				drive_expected.push_back(compute_drive(cur_tick));
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
					gap_left = $urandom_range(0, 2);
					in_valid <= 1'b0;
				end else if (tick_pending.size() != 0) begin
					cur_tick = tick_pending.pop_front();
					start_move       <= cur_tick.start_move;
					target_heading   <= cur_tick.target_heading;
					measured_heading <= cur_tick.measured_heading;
					in_valid         <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare against the oldest expectation, stall at random
	always @(posedge clk) begin : result_check
		drive_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					$error("unexpected result transaction");
					fail_count++;
				end else begin
					want = drive_expected.pop_front();
					if (left_drive !== want.left_drive) begin
						$error("left_drive: expected %0d, got %0d", want.left_drive, left_drive);
						fail_count++;
					end
					if (right_drive !== want.right_drive) begin
						$error("right_drive: expected %0d, got %0d", want.right_drive,
							right_drive);
						fail_count++;
					end
					if (move_done !== want.move_done) begin
						$error("move_done: expected %0b, got %0b", want.move_done, move_done);
						fail_count++;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [HEAD_W-1:0] clip_heading(int v);
		if (v < 0)
			return '0;
		if (v > 4095)
			return '1;
		return v[HEAD_W-1:0];
	endfunction

	task automatic push_tick(logic s, int tgt, int meas);
		tick_t t;
		t.start_move       = s;
		t.target_heading   = clip_heading(tgt);
		t.measured_heading = clip_heading(meas);
		tick_pending.push_back(t);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (tick_pending.size() != 0 || in_valid || drive_expected.size() != 0);
	endtask

	// Write one register and mirror it, masked to its width
	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PROP_GAIN:   gains.prop_gain        = value;
			CFG_INTEG_GAIN:  gains.integ_gain       = value;
			CFG_DERIV_GAIN:  gains.deriv_gain       = value;
			CFG_MAX_OUTPUT:  gains.max_output       = value[6:0];
			CFG_MIN_SPEED:   gains.min_speed        = value[6:0];
			CFG_SETTLE_THR:  gains.settle_threshold = value[11:0];
			CFG_SETTLE_TIME: gains.settle_time      = value;
			CFG_SLEW_LIMIT:  gains.slew_limit       = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_gains(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
			logic [15:0] maxo, logic [15:0] mins, logic [15:0] thr,
			logic [15:0] settle, logic [15:0] slew);
		write_reg(CFG_PROP_GAIN, kp);
		write_reg(CFG_INTEG_GAIN, ki);
		write_reg(CFG_DERIV_GAIN, kd);
		write_reg(CFG_MAX_OUTPUT, maxo);
		write_reg(CFG_MIN_SPEED, mins);
		write_reg(CFG_SETTLE_THR, thr);
		write_reg(CFG_SETTLE_TIME, settle);
		write_reg(CFG_SLEW_LIMIT, slew);
	endtask

	// Mostly a value in range, now and then any 16-bit pattern
	function automatic logic [15:0] pick_setting(int lo, int hi);
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom);
		return 16'($urandom_range(lo, hi));
	endfunction

	// Queue moves: a start, an approach toward the target, a linger in band;
	// with some noise transactions and moves that lack the start flag
	task automatic queue_moves(int count);
		int base, tgt, meas, n, k, f, j, w;
		logic with_start;
		base = tick_pending.size();
		while (tick_pending.size() - base < count) begin
			if ($urandom_range(0, 5) == 0) begin
				push_tick($urandom_range(0, 7) == 0, $urandom_range(0, 4095),
					$urandom_range(0, 4095));
			end else begin
				tgt = ($urandom_range(0, 9) == 0) ? $urandom_range(3600, 4095)
					: $urandom_range(0, 3599);
				meas = $urandom_range(0, 4095);
				with_start = ($urandom_range(0, 4) != 0);
				n = $urandom_range(3, 20);
				for (k = 0; k < n; k++) begin
					push_tick(k == 0 && with_start, tgt, meas);
					f = $urandom_range(2, 6);
					j = $urandom_range(0, 6);
					meas = clip_heading(meas + (tgt - meas) * f / 8 + j - 3);
				end
				w = (gains.settle_threshold < 40) ? gains.settle_threshold + 1 : 40;
				n = $urandom_range(0, 30);
				for (k = 0; k < n; k++) begin
					j = $urandom_range(0, 2 * w);
					push_tick(1'b0, tgt, tgt + j - w);
				end
			end
		end
	endtask

	initial begin
		int ph, k;
		gains.prop_gain        = RST_PROP_GAIN;
		gains.integ_gain       = RST_INTEG_GAIN;
		gains.deriv_gain       = RST_DERIV_GAIN;
		gains.max_output       = RST_MAX_OUTPUT;
		gains.min_speed        = RST_MIN_SPEED;
		gains.settle_threshold = RST_SETTLE_THR;
		gains.settle_time      = RST_SETTLE_TIME;
		gains.slew_limit       = RST_SLEW_LIMIT;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Default settings: heading extremes, band edge, settling and restart
		push_tick(1'b1, 0, 0);
		push_tick(1'b0, 4095, 0);
		push_tick(1'b0, 0, 4095);
		push_tick(1'b0, 3599, 0);
		push_tick(1'b0, 0, 3599);
		push_tick(1'b0, 2048, 2047);
		push_tick(1'b0, 1810, 1800);
		push_tick(1'b0, 1811, 1800);
		for (k = 0; k < 12; k++)
			push_tick(1'b0, 1800, 1795 + k);
		push_tick(1'b1, 1800, 1800);
		push_tick(1'b0, 4095, 4095);
		wait_drained();

		// Zero output off target turns into reverse minimum speed; zero settle time
		set_gains(0, 0, 0, 100, 40, 10, 0, 255);
		push_tick(1'b1, 1850, 1800);
		push_tick(1'b0, 1750, 1800);
		push_tick(1'b0, 1805, 1800);
		push_tick(1'b0, 1800, 1800);
		wait_drained();

		// Random phases, extremes first, no idling in the last one
		for (ph = 0; ph < 10; ph++) begin
			if (ph == 9) begin
				in_gap_odds    = 0;
				out_stall_odds = 0;
			end else begin
				in_gap_odds    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
				out_stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 6);
			end
			case (ph)
				0: set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 127, 127, 3599, 16'hFFFF, 255);
				1: set_gains(0, 0, 0, 0, 0, 0, 0, 0);
				default: set_gains(pick_setting(0, 1023), pick_setting(0, 63),
					pick_setting(0, 2047), pick_setting(0, 127), pick_setting(0, 60),
					pick_setting(0, 60), pick_setting(0, 200), pick_setting(1, 255));
			endcase
			queue_moves(175);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
